// ===== design/csrsmv_pkg.sv =====
// ----------------------------------------------------------------------------
// csrsmv_pkg
// Shared types and constants of the CSR sparse matrix-vector multiplier.
// ----------------------------------------------------------------------------
package csrsmv_pkg;

  localparam int INDEX_W     = 10;
  localparam int DATA_W      = 32;
  localparam int ROW_W       = 16;
  localparam int ACC_W       = 64;
  localparam int FRAC_W      = 16;
  localparam int QUEUE_DEPTH = 2;

  // input opcodes
  typedef enum logic [1:0] {
    OP_LOAD     = 2'd0,
    OP_NONZERO  = 2'd1,
    OP_ROW_END  = 2'd2,
    OP_RESERVED = 2'd3
  } opcode_e;

  // commands handed from front to back
  typedef enum logic [1:0] {
    CMD_LOAD,
    CMD_MAC,
    CMD_ROW_END
  } cmd_kind_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_ACC,
    ST_ROUND,
    ST_EMIT
  } back_state_e;

  typedef struct packed {
    cmd_kind_e           kind;
    logic [INDEX_W-1:0]  index;
    logic [DATA_W-1:0]   value;
  } cmd_t;

  typedef struct packed {
    logic [DATA_W-1:0] row_sum;
    logic [ROW_W-1:0]  row_number;
    logic              saturated;
  } result_t;

endpackage

// ===== design/csr_sparse_matrix_vector_multiply.sv =====
// ----------------------------------------------------------------------------
// csr_sparse_matrix_vector_multiply
// CSR sparse matrix times dense vector in signed fixed point.
// ----------------------------------------------------------------------------
// Load the vector first (opcode 0: index, value), then stream the matrix in
// row order: opcode 1 carries a column index and a nonzero, opcode 2 closes
// the current row and produces one result transaction with the rounded,
// clamped row sum, the row number (from zero, wrapping at 16 bits) and a flag
// that is set when the 64-bit accumulator or the final conversion saturated.
// Opcode 3 is accepted and dropped. Values are signed with 16 fraction bits;
// only the low VALUE_WIDTH bits of value_i are used and row_sum_o is
// sign-extended from VALUE_WIDTH. Loads to an index at or beyond VECTOR_DEPTH
// are dropped and nonzeros there add nothing; a vector entry that was never
// loaded reads back undefined. The vector store needs no clearing pass after
// reset. The front takes one transaction per cycle, while it is not full, into
// a two-entry command queue; the back executes commands one at a time and sets
// the sustained rate: a load is one RAM write, a nonzero is a RAM read, a
// multiply and a saturating accumulate, and an end of row is a round, then a
// clamp and push that waits while the two-entry result queue is full.
module csr_sparse_matrix_vector_multiply #(
  parameter int VECTOR_DEPTH = 1024,
  parameter int VALUE_WIDTH  = 32
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           push,
  output logic                           full,
  input  logic [1:0]                     opcode_i,
  input  logic [csrsmv_pkg::INDEX_W-1:0] index_i,
  input  logic [csrsmv_pkg::DATA_W-1:0]  value_i,
  output logic                           empty,
  input  logic                           pop,
  output logic [csrsmv_pkg::DATA_W-1:0]  row_sum_o,
  output logic [csrsmv_pkg::ROW_W-1:0]   row_number_o,
  output logic                           saturated_o
);

  import csrsmv_pkg::*;

  cmd_t cmd;
  logic cmd_empty;
  logic cmd_pop;

  // front: decode and queue
  csrsmv_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .full_o      (full),
    .opcode_i    (opcode_i),
    .index_i     (index_i),
    .value_i     (value_i),
    .cmd_o       (cmd),
    .cmd_empty_o (cmd_empty),
    .cmd_pop_i   (cmd_pop)
  );

  // back: vector store, MAC, rounding and result queue
  csrsmv_back #(
    .VECTOR_DEPTH (VECTOR_DEPTH),
    .VALUE_WIDTH  (VALUE_WIDTH)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .cmd_empty_i  (cmd_empty),
    .cmd_pop_o    (cmd_pop),
    .empty_o      (empty),
    .pop_i        (pop),
    .row_sum_o    (row_sum_o),
    .row_number_o (row_number_o),
    .saturated_o  (saturated_o)
  );

endmodule

// ===== design/csrsmv_ram.sv =====
// ----------------------------------------------------------------------------
// csrsmv_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module csrsmv_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

// ===== design/csrsmv_fifo.sv =====
// ----------------------------------------------------------------------------
// csrsmv_fifo
// Small register FIFO; push when full and pop when empty are ignored.
// ----------------------------------------------------------------------------
module csrsmv_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] data_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic [WIDTH-1:0] data_o,
  output logic             empty_o
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [PW-1:0]    wr_ptr_q, wr_ptr_d;
  logic [PW-1:0]    rd_ptr_q, rd_ptr_d;
  logic [CW-1:0]    count_q, count_d;
  logic             do_push, do_pop;

  assign full_o  = (count_q == CW'(DEPTH));
  assign empty_o = (count_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign data_o  = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + PW'(1);
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + PW'(1);
    end
    if (do_push && !do_pop) begin
      count_d = count_q + CW'(1);
    end else if (do_pop && !do_push) begin
      count_d = count_q - CW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

// ===== design/csrsmv_front.sv =====
// ----------------------------------------------------------------------------
// csrsmv_front
// Accepts input transactions, decodes the opcode and queues commands.
// ----------------------------------------------------------------------------
module csrsmv_front (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           push_i,
  output logic                           full_o,
  input  logic [1:0]                     opcode_i,
  input  logic [csrsmv_pkg::INDEX_W-1:0] index_i,
  input  logic [csrsmv_pkg::DATA_W-1:0]  value_i,
  output csrsmv_pkg::cmd_t               cmd_o,
  output logic                           cmd_empty_o,
  input  logic                           cmd_pop_i
);

  import csrsmv_pkg::*;

  cmd_t                cmd_in;
  logic                keep;
  logic [$bits(cmd_t)-1:0] q_out;

  always_comb begin
    cmd_in.index = index_i;
    cmd_in.value = value_i;
    cmd_in.kind  = CMD_LOAD;
    keep         = 1'b1;
    case (opcode_e'(opcode_i))
      OP_LOAD:     cmd_in.kind = CMD_LOAD;
      OP_NONZERO:  cmd_in.kind = CMD_MAC;
      OP_ROW_END:  cmd_in.kind = CMD_ROW_END;
      OP_RESERVED: keep        = 1'b0;   // accepted and dropped
      default:     keep        = 1'b0;
    endcase
  end

  csrsmv_fifo #(
    .WIDTH ($bits(cmd_t)),
    .DEPTH (QUEUE_DEPTH)
  ) u_cmd_q (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push_i && !full_o && keep),
    .data_i  (cmd_in),
    .full_o  (full_o),
    .pop_i   (cmd_pop_i),
    .data_o  (q_out),
    .empty_o (cmd_empty_o)
  );

  assign cmd_o = cmd_t'(q_out);

endmodule

// ===== design/csrsmv_back.sv =====
// ----------------------------------------------------------------------------
// csrsmv_back
// Executes commands: vector store writes, multiply-accumulate, row output.
// ----------------------------------------------------------------------------
module csrsmv_back #(
  parameter int VECTOR_DEPTH = 1024,
  parameter int VALUE_WIDTH  = 32
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  csrsmv_pkg::cmd_t              cmd_i,
  input  logic                          cmd_empty_i,
  output logic                          cmd_pop_o,
  output logic                          empty_o,
  input  logic                          pop_i,
  output logic [csrsmv_pkg::DATA_W-1:0] row_sum_o,
  output logic [csrsmv_pkg::ROW_W-1:0]  row_number_o,
  output logic                          saturated_o
);

  import csrsmv_pkg::*;

  localparam int AW  = $clog2(VECTOR_DEPTH);
  localparam int PW  = 2 * VALUE_WIDTH;
  localparam int RW  = ACC_W - FRAC_W + 1;
  localparam logic signed [ACC_W-1:0] ACC_MAX = {1'b0, {(ACC_W - 1){1'b1}}};
  localparam logic signed [ACC_W-1:0] ACC_MIN = {1'b1, {(ACC_W - 1){1'b0}}};
  localparam logic signed [RW-1:0] SUM_MAX =
    RW'((64'sd1 <<< (VALUE_WIDTH - 1)) - 64'sd1);
  localparam logic signed [RW-1:0] SUM_MIN = -SUM_MAX - RW'(1);

  back_state_e state_q, state_d;

  logic signed [VALUE_WIDTH-1:0] val_q, val_d;
  logic                          hit_q, hit_d;
  logic signed [PW-1:0]          prod_q, prod_d;
  logic signed [ACC_W-1:0]       acc_q, acc_d;
  logic                          sat_q, sat_d;
  logic [ROW_W-1:0]              row_q, row_d;
  logic signed [RW-1:0]          rnd_q, rnd_d;

  logic [16:0]                   idx_ext;
  logic                          in_range;
  logic [AW-1:0]                 addr;
  logic                          ram_we, ram_re;
  logic [VALUE_WIDTH-1:0]        ram_rdata;
  logic signed [VALUE_WIDTH-1:0] vec_s;
  logic signed [ACC_W-1:0]       prod_ext, sum_w;
  logic                          ovf;
  logic signed [VALUE_WIDTH-1:0] sum_vw;
  logic                          clip;
  result_t                       res;
  logic                          res_push, res_full;
  logic [$bits(result_t)-1:0]    res_bits;
  result_t                       res_out;

  assign idx_ext  = 17'(cmd_i.index);
  assign in_range = (idx_ext < 17'(VECTOR_DEPTH));
  assign addr     = idx_ext[AW-1:0];
  assign vec_s    = $signed(ram_rdata);

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (!cmd_empty_i) begin
          case (cmd_i.kind)
            CMD_MAC:     state_d = ST_MUL;
            CMD_ROW_END: state_d = ST_ROUND;
            default:     state_d = ST_IDLE;
          endcase
        end
      end
      ST_MUL:   state_d = ST_ACC;
      ST_ACC:   state_d = ST_IDLE;
      ST_ROUND: state_d = ST_EMIT;
      ST_EMIT: begin
        if (!res_full) begin
          state_d = ST_IDLE;
        end
      end
      default:  state_d = ST_IDLE;
    endcase
  end

  // control outputs
  always_comb begin
    cmd_pop_o = 1'b0;
    ram_we    = 1'b0;
    ram_re    = 1'b0;
    res_push  = 1'b0;
    case (state_q)
      ST_IDLE: begin
        cmd_pop_o = !cmd_empty_i;
        ram_we    = !cmd_empty_i && (cmd_i.kind == CMD_LOAD) && in_range;
        ram_re    = !cmd_empty_i && (cmd_i.kind == CMD_MAC) && in_range;
      end
      ST_EMIT:  res_push = !res_full;
      default:  cmd_pop_o = 1'b0;
    endcase
  end

  // datapath
  always_comb begin
    val_d    = val_q;
    hit_d    = hit_q;
    prod_d   = prod_q;
    acc_d    = acc_q;
    sat_d    = sat_q;
    row_d    = row_q;
    rnd_d    = rnd_q;
    prod_ext = 64'(prod_q);
    sum_w    = acc_q + prod_ext;
    ovf      = (acc_q[ACC_W-1] == prod_ext[ACC_W-1]) &&
               (sum_w[ACC_W-1] != acc_q[ACC_W-1]);

    if (state_q == ST_IDLE && !cmd_empty_i && cmd_i.kind == CMD_MAC) begin
      val_d = $signed(cmd_i.value[VALUE_WIDTH-1:0]);
      hit_d = in_range;
    end
    if (state_q == ST_MUL) begin
      prod_d = hit_q ? PW'(val_q * vec_s) : '0;
    end
    if (state_q == ST_ACC) begin
      if (ovf) begin
        acc_d = prod_ext[ACC_W-1] ? ACC_MIN : ACC_MAX;
        sat_d = 1'b1;
      end else begin
        acc_d = sum_w;
      end
    end
    if (state_q == ST_ROUND) begin
      // floor to 16 fraction bits, then round half up
      rnd_d = RW'($signed(acc_q[ACC_W-1:FRAC_W])) + RW'(acc_q[FRAC_W-1]);
    end
    if (res_push) begin
      acc_d = '0;
      sat_d = 1'b0;
      row_d = row_q + ROW_W'(1);
    end
  end

  // final clamp to the value range
  always_comb begin
    clip = 1'b0;
    if (rnd_q > SUM_MAX) begin
      sum_vw = SUM_MAX[VALUE_WIDTH-1:0];
      clip   = 1'b1;
    end else if (rnd_q < SUM_MIN) begin
      sum_vw = SUM_MIN[VALUE_WIDTH-1:0];
      clip   = 1'b1;
    end else begin
      sum_vw = rnd_q[VALUE_WIDTH-1:0];
    end
    res.row_sum    = DATA_W'(sum_vw);
    res.row_number = row_q;
    res.saturated  = sat_q | clip;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      acc_q   <= '0;
      sat_q   <= 1'b0;
      row_q   <= '0;
    end else begin
      state_q <= state_d;
      acc_q   <= acc_d;
      sat_q   <= sat_d;
      row_q   <= row_d;
    end
  end

  always_ff @(posedge clk_i) begin
    val_q  <= val_d;
    hit_q  <= hit_d;
    prod_q <= prod_d;
    rnd_q  <= rnd_d;
  end

  csrsmv_ram #(
    .WIDTH (VALUE_WIDTH),
    .DEPTH (VECTOR_DEPTH)
  ) u_vec_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (addr),
    .wdata_i (cmd_i.value[VALUE_WIDTH-1:0]),
    .re_i    (ram_re),
    .raddr_i (addr),
    .rdata_o (ram_rdata)
  );

  csrsmv_fifo #(
    .WIDTH ($bits(result_t)),
    .DEPTH (QUEUE_DEPTH)
  ) u_res_q (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (res_push),
    .data_i  (res),
    .full_o  (res_full),
    .pop_i   (pop_i),
    .data_o  (res_bits),
    .empty_o (empty_o)
  );

  assign res_out      = result_t'(res_bits);
  assign row_sum_o    = res_out.row_sum;
  assign row_number_o = res_out.row_number;
  assign saturated_o  = res_out.saturated;

endmodule

// ===== design/csrsmv_checker.sv =====
// ----------------------------------------------------------------------------
// csrsmv_checker
// Port-level assertions for the sparse matrix-vector multiplier.
// ----------------------------------------------------------------------------
module csrsmv_checker #(
  parameter int VALUE_WIDTH = 32
) (
  input logic                           clk_i,
  input logic                           rst_ni,
  input logic                           push,
  input logic                           full,
  input logic [1:0]                     opcode_i,
  input logic [csrsmv_pkg::INDEX_W-1:0] index_i,
  input logic [csrsmv_pkg::DATA_W-1:0]  value_i,
  input logic                           empty,
  input logic                           pop,
  input logic [csrsmv_pkg::DATA_W-1:0]  row_sum_o,
  input logic [csrsmv_pkg::ROW_W-1:0]   row_number_o,
  input logic                           saturated_o
);

  import csrsmv_pkg::*;

  logic             seen_q;
  logic [ROW_W-1:0] last_row_q;
  logic             out_txn;

  assign out_txn = pop && !empty;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seen_q <= 1'b0;
    end else if (out_txn) begin
      seen_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_txn) begin
      last_row_q <= row_number_o;
    end
  end

  // no result can be ready the cycle after reset
  a_reset_empty: assert property (@(posedge clk_i) !rst_ni |=> empty)
    else $error("result queue not empty after reset");

  // accepted input fields are driven
  a_input_known: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push && !full) |-> !$isunknown({opcode_i, index_i, value_i}))
    else $error("input transaction with unknown fields");

  // waiting result holds
  a_result_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && !pop) |=> (!empty && $stable(row_sum_o) &&
                          $stable(row_number_o) && $stable(saturated_o)))
    else $error("waiting result changed");

  // rows come out in order
  a_row_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_txn && seen_q) |-> (row_number_o == last_row_q + ROW_W'(1)))
    else $error("row number skipped or repeated");

  // row sum is a sign-extended VALUE_WIDTH value
  a_sum_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty |-> ((&row_sum_o[DATA_W-1:VALUE_WIDTH-1]) ||
                (~|row_sum_o[DATA_W-1:VALUE_WIDTH-1])))
    else $error("row sum outside value range");

endmodule

bind csr_sparse_matrix_vector_multiply csrsmv_checker #(
  .VALUE_WIDTH (VALUE_WIDTH)
) u_csrsmv_checker (.*);
